// File: design/fsr_pkg.sv
// Shared widths, codes, constants and transaction types of the FSR force estimator.
package fsr_pkg;

  localparam int ADC_BITS   = 10;
  localparam int MV_W       = 16;
  localparam int OHM_W      = 20;
  localparam int G_W        = 20;
  localparam int F_W        = 16;
  localparam int ST_W       = 2;
  localparam int DIV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int VPROD_W = ADC_BITS + MV_W;
  localparam int RPROD_W = MV_W + OHM_W;

  localparam int VSTEPS = VPROD_W;
  localparam int RSTEPS = RPROD_W;
  localparam int CSTEPS = G_W;
  localparam int FSTEPS = G_W;

  localparam logic [G_W-1:0] G_SCALE   = 20'd1000000;
  localparam logic [G_W-1:0] G_MAX     = 20'd1000000;
  localparam logic [F_W-1:0] FORCE_MAX = 16'hFFFF;

  localparam logic [MV_W-1:0]  RST_SUPPLY     = 16'd5000;
  localparam logic [OHM_W-1:0] RST_DIVIDER    = 20'd10000;
  localparam logic [MV_W-1:0]  RST_FULL_SCALE = 16'd1023;
  localparam logic [G_W-1:0]   RST_KNEE       = 20'd1000;
  localparam logic [DIV_W-1:0] RST_LOW_DIV    = 8'd80;
  localparam logic [DIV_W-1:0] RST_HIGH_DIV   = 8'd30;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOPRESS = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY     = 3'd0,
    CFG_DIVIDER    = 3'd1,
    CFG_FULL_SCALE = 3'd2,
    CFG_KNEE       = 3'd3,
    CFG_LOW_DIV    = 3'd4,
    CFG_HIGH_DIV   = 3'd5
  } cfg_index_t;

  // Divisor fields already have zero replaced by one.
  typedef struct packed {
    logic [MV_W-1:0]  supply;
    logic [OHM_W-1:0] divider;
    logic [MV_W-1:0]  full_scale;
    logic [G_W-1:0]   knee;
    logic [DIV_W-1:0] low_div;
    logic [DIV_W-1:0] high_div;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [ADC_BITS-1:0] sample;
  } sample_beat_t;

  typedef struct packed {
    logic            valid;
    logic [MV_W-1:0] v;
  } volt_beat_t;

  typedef struct packed {
    logic               valid;
    logic [MV_W-1:0]    v;
    logic [RPROD_W-1:0] r;
    logic               zero;
  } res_beat_t;

  typedef struct packed {
    logic            valid;
    logic [MV_W-1:0] v;
    logic [G_W-1:0]  g;
    status_t         st;
  } cond_beat_t;

  typedef struct packed {
    logic            valid;
    logic [MV_W-1:0] v;
    logic [G_W-1:0]  g;
    logic [F_W-1:0]  f;
    status_t         st;
  } force_beat_t;

endpackage

// File: design/fsr_sample_if.sv
// Input channel: one ADC sample per transaction.
interface fsr_sample_if;
  import fsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// File: design/fsr_result_if.sv
// Output channel: voltage, conductance, force and status per transaction.
interface fsr_result_if;
  import fsr_pkg::*;

  logic            valid;
  logic            ready;
  logic [MV_W-1:0] sense_millivolts;
  logic [G_W-1:0]  conductance_micromho;
  logic [F_W-1:0]  force_estimate;
  logic [ST_W-1:0] status_code;

  modport source (output valid, output sense_millivolts, output conductance_micromho,
                  output force_estimate, output status_code, input ready);
  modport sink (input valid, input sense_millivolts, input conductance_micromho,
                input force_estimate, input status_code, output ready);
endinterface

// File: design/fsr_volt.sv
// Sample to millivolts: multiply by supply, then a pipelined restoring divide by full scale.
module fsr_volt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  fsr_pkg::cfg_t        cfg,
  input  fsr_pkg::sample_beat_t in_beat,
  output fsr_pkg::volt_beat_t  out_beat
);
  import fsr_pkg::*;

  typedef struct packed {
    logic [VPROD_W-1:0] acc;
    logic [MV_W-1:0]    rem;
    logic               clamp;
  } vstage_t;

  function automatic vstage_t vstep(vstage_t s, logic [MV_W-1:0] den);
    logic [MV_W:0] trial;
    vstage_t       n;
    n     = s;
    trial = {s.rem, s.acc[VPROD_W-1]};
    if (trial >= {1'b0, den}) begin
      n.rem = MV_W'(trial - {1'b0, den});
      n.acc = {s.acc[VPROD_W-2:0], 1'b1};
    end else begin
      n.rem = trial[MV_W-1:0];
      n.acc = {s.acc[VPROD_W-2:0], 1'b0};
    end
    return n;
  endfunction

  vstage_t         stg [VSTEPS+1];
  logic [VSTEPS:0] vld;
  logic            out_vld;
  logic [MV_W-1:0] out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[VSTEPS-1:0], in_beat.valid};
      out_vld <= vld[VSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].acc   <= VPROD_W'(in_beat.sample) * VPROD_W'(cfg.supply);
      stg[0].rem   <= '0;
      stg[0].clamp <= (MV_W'(in_beat.sample) >= cfg.full_scale);
    end
  end

  for (genvar j = 0; j < VSTEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) stg[j+1] <= vstep(stg[j], cfg.full_scale);
    end
  end

  // Samples at or above full scale read as the supply.
  always_ff @(posedge clk) begin
    if (adv) out_v <= stg[VSTEPS].clamp ? cfg.supply : stg[VSTEPS].acc[MV_W-1:0];
  end

  assign out_beat.valid = out_vld;
  assign out_beat.v     = out_v;
endmodule

// File: design/fsr_res.sv
// Resistance: (supply - v) * divider, then a pipelined restoring divide by v.
module fsr_res (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  fsr_pkg::cfg_t       cfg,
  input  fsr_pkg::volt_beat_t in_beat,
  output fsr_pkg::res_beat_t  out_beat
);
  import fsr_pkg::*;

  typedef struct packed {
    logic [RPROD_W-1:0] acc;
    logic [MV_W-1:0]    rem;
    logic [MV_W-1:0]    v;
    logic               zero;
  } rstage_t;

  function automatic rstage_t rstep(rstage_t s);
    logic [MV_W:0] trial;
    rstage_t       n;
    n     = s;
    trial = {s.rem, s.acc[RPROD_W-1]};
    if (trial >= {1'b0, s.v}) begin
      n.rem = MV_W'(trial - {1'b0, s.v});
      n.acc = {s.acc[RPROD_W-2:0], 1'b1};
    end else begin
      n.rem = trial[MV_W-1:0];
      n.acc = {s.acc[RPROD_W-2:0], 1'b0};
    end
    return n;
  endfunction

  rstage_t         stg [RSTEPS+1];
  logic [RSTEPS:0] vld;
  logic            out_vld;
  rstage_t         out_stg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[RSTEPS-1:0], in_beat.valid};
      out_vld <= vld[RSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].acc  <= RPROD_W'(cfg.supply - in_beat.v) * RPROD_W'(cfg.divider);
      stg[0].rem  <= '0;
      stg[0].v    <= in_beat.v;
      stg[0].zero <= (in_beat.v == '0);
    end
  end

  // A zero divisor yields junk here; the zero flag overrides it downstream.
  for (genvar j = 0; j < RSTEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) stg[j+1] <= rstep(stg[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_stg <= stg[RSTEPS];
  end

  assign out_beat.valid = out_vld;
  assign out_beat.v     = out_stg.v;
  assign out_beat.r     = out_stg.acc;
  assign out_beat.zero  = out_stg.zero;
endmodule

// File: design/fsr_cond.sv
// Conductance: pipelined restoring divide of the micromho scale by resistance, plus status.
module fsr_cond (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  fsr_pkg::res_beat_t  in_beat,
  output fsr_pkg::cond_beat_t out_beat
);
  import fsr_pkg::*;

  typedef struct packed {
    logic [G_W-1:0]  acc;
    logic [G_W-1:0]  rem;
    logic [G_W-1:0]  den;
    logic [MV_W-1:0] v;
    status_t         st;
  } cstage_t;

  function automatic cstage_t cstep(cstage_t s);
    logic [G_W:0] trial;
    cstage_t      n;
    n     = s;
    trial = {s.rem, s.acc[G_W-1]};
    if (trial >= {1'b0, s.den}) begin
      n.rem = G_W'(trial - {1'b0, s.den});
      n.acc = {s.acc[G_W-2:0], 1'b1};
    end else begin
      n.rem = trial[G_W-1:0];
      n.acc = {s.acc[G_W-2:0], 1'b0};
    end
    return n;
  endfunction

  cstage_t         stg [CSTEPS+1];
  logic [CSTEPS:0] vld;
  logic            out_vld;
  logic [MV_W-1:0] out_v;
  logic [G_W-1:0]  out_g;
  status_t         out_st;
  logic [G_W-1:0]  g_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[CSTEPS-1:0], in_beat.valid};
      out_vld <= vld[CSTEPS];
    end
  end

  // Resistance above the scale gives zero conductance: an all-ones divisor does that.
  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].acc <= G_SCALE;
      stg[0].rem <= '0;
      stg[0].den <= (in_beat.r > RPROD_W'(G_SCALE)) ? '1 : in_beat.r[G_W-1:0];
      stg[0].v   <= in_beat.v;
      if (in_beat.zero)           stg[0].st <= ST_NOPRESS;
      else if (in_beat.r == '0)   stg[0].st <= ST_SAT;
      else                        stg[0].st <= ST_OK;
    end
  end

  for (genvar j = 0; j < CSTEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) stg[j+1] <= cstep(stg[j]);
    end
  end

  always_comb begin
    case (stg[CSTEPS].st)
      ST_OK:   g_sel = stg[CSTEPS].acc;
      ST_SAT:  g_sel = G_MAX;
      default: g_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_v  <= stg[CSTEPS].v;
      out_g  <= g_sel;
      out_st <= stg[CSTEPS].st;
    end
  end

  assign out_beat.valid = out_vld;
  assign out_beat.v     = out_v;
  assign out_beat.g     = out_g;
  assign out_beat.st    = out_st;
endmodule

// File: design/fsr_force.sv
// Force: pick the slope around the knee, pipelined restoring divide, saturate.
module fsr_force (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  fsr_pkg::cfg_t        cfg,
  input  fsr_pkg::cond_beat_t  in_beat,
  output fsr_pkg::force_beat_t out_beat
);
  import fsr_pkg::*;

  typedef struct packed {
    logic [G_W-1:0]   acc;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [MV_W-1:0]  v;
    logic [G_W-1:0]   g;
    status_t          st;
  } fstage_t;

  function automatic fstage_t fstep(fstage_t s);
    logic [DIV_W:0] trial;
    fstage_t        n;
    n     = s;
    trial = {s.rem, s.acc[G_W-1]};
    if (trial >= {1'b0, s.den}) begin
      n.rem = DIV_W'(trial - {1'b0, s.den});
      n.acc = {s.acc[G_W-2:0], 1'b1};
    end else begin
      n.rem = trial[DIV_W-1:0];
      n.acc = {s.acc[G_W-2:0], 1'b0};
    end
    return n;
  endfunction

  fstage_t         stg [FSTEPS+1];
  logic [FSTEPS:0] vld;
  logic            out_vld;
  logic [MV_W-1:0] out_v;
  logic [G_W-1:0]  out_g;
  logic [F_W-1:0]  out_f;
  status_t         out_st;
  logic [F_W-1:0]  f_sel;
  logic            above;

  assign above = (in_beat.g > cfg.knee);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[FSTEPS-1:0], in_beat.valid};
      out_vld <= vld[FSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].acc <= above ? (in_beat.g - cfg.knee) : in_beat.g;
      stg[0].rem <= '0;
      stg[0].den <= above ? cfg.high_div : cfg.low_div;
      stg[0].v   <= in_beat.v;
      stg[0].g   <= in_beat.g;
      stg[0].st  <= in_beat.st;
    end
  end

  for (genvar j = 0; j < FSTEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) stg[j+1] <= fstep(stg[j]);
    end
  end

  always_comb begin
    case (stg[FSTEPS].st)
      ST_OK: begin
        f_sel = (stg[FSTEPS].acc > G_W'(FORCE_MAX)) ? FORCE_MAX : stg[FSTEPS].acc[F_W-1:0];
      end
      ST_SAT:  f_sel = FORCE_MAX;
      default: f_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_v  <= stg[FSTEPS].v;
      out_g  <= stg[FSTEPS].g;
      out_f  <= f_sel;
      out_st <= stg[FSTEPS].st;
    end
  end

  assign out_beat.valid = out_vld;
  assign out_beat.v     = out_v;
  assign out_beat.g     = out_g;
  assign out_beat.f     = out_f;
  assign out_beat.st    = out_st;
endmodule

// File: design/fsr_adc_to_force_top.sv
// Top level of the FSR force estimator: config registers, pipeline control, channels.
// Datapath: four chained restoring dividers, at one quotient bit per stage.
// Throughput: one sample transaction per cycle; the whole pipeline holds while a
//   result waits, so input ready drops only when the output register is full and stalled.
// Reset (rst, synchronous, active high): clears all valid bits and loads the
//   config registers with their defaults; payload registers are not reset.
module fsr_adc_to_force_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsr_pkg::CFG_DATA_W-1:0] cfg_data,
  fsr_sample_if.sink                    sample,
  fsr_result_if.source                  result
);
  import fsr_pkg::*;

  logic [MV_W-1:0]  supply;
  logic [OHM_W-1:0] divider;
  logic [MV_W-1:0]  full_scale;
  logic [G_W-1:0]   knee;
  logic [DIV_W-1:0] low_div;
  logic [DIV_W-1:0] high_div;

  cfg_t         cfg;
  logic         adv;
  sample_beat_t in_beat;
  volt_beat_t   volt_beat;
  res_beat_t    res_beat;
  cond_beat_t   cond_beat;
  force_beat_t  force_beat;

  // Keep config writes to idle; the block does not check. Unlisted indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      supply     <= RST_SUPPLY;
      divider    <= RST_DIVIDER;
      full_scale <= RST_FULL_SCALE;
      knee       <= RST_KNEE;
      low_div    <= RST_LOW_DIV;
      high_div   <= RST_HIGH_DIV;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SUPPLY:     supply     <= cfg_data[MV_W-1:0];
        CFG_DIVIDER:    divider    <= cfg_data[OHM_W-1:0];
        CFG_FULL_SCALE: full_scale <= cfg_data[MV_W-1:0];
        CFG_KNEE:       knee       <= cfg_data[G_W-1:0];
        CFG_LOW_DIV:    low_div    <= cfg_data[DIV_W-1:0];
        CFG_HIGH_DIV:   high_div   <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // A divisor written as zero acts as one.
  always_comb begin
    cfg.supply     = supply;
    cfg.divider    = divider;
    cfg.full_scale = (full_scale == '0) ? MV_W'(1) : full_scale;
    cfg.knee       = knee;
    cfg.low_div    = (low_div == '0) ? DIV_W'(1) : low_div;
    cfg.high_div   = (high_div == '0) ? DIV_W'(1) : high_div;
  end

  // Advance every stage together unless the output register holds an untaken result.
  assign adv          = !force_beat.valid || result.ready;
  assign sample.ready = adv;

  assign in_beat.valid  = sample.valid;
  assign in_beat.sample = sample.adc_sample;

  fsr_volt u_volt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_beat  (in_beat),
    .out_beat (volt_beat)
  );

  fsr_res u_res (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_beat  (volt_beat),
    .out_beat (res_beat)
  );

  fsr_cond u_cond (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_beat  (res_beat),
    .out_beat (cond_beat)
  );

  fsr_force u_force (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_beat  (cond_beat),
    .out_beat (force_beat)
  );

  // Drive the result channel straight from the output register.
  assign result.valid                = force_beat.valid;
  assign result.sense_millivolts     = force_beat.v;
  assign result.conductance_micromho = force_beat.g;
  assign result.force_estimate       = force_beat.f;
  assign result.status_code          = force_beat.st;

  a_nopress_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status_code == ST_NOPRESS |->
      result.force_estimate == '0 && result.conductance_micromho == '0)
    else $error("no-pressure result with nonzero conductance or force");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status_code == ST_SAT |->
      result.force_estimate == FORCE_MAX && result.conductance_micromho == G_MAX)
    else $error("saturated result not at maximum");

  a_ok_voltage: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status_code == ST_OK |-> result.sense_millivolts != '0)
    else $error("ok status with zero voltage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("input accepted while output stalled");
endmodule

// File: tb/fsr_adc_to_force_top_test.sv
// Self-checking testbench of the FSR force estimator top level.
`timescale 1ns / 100ps

module fsr_adc_to_force_top_test;
  import fsr_pkg::*;

  // Pipeline depth of the top level; used for the final settle.
  localparam int LATENCY     = ADC_BITS + 100;
  // Watchdog bound, with room for the slowest run (the heaviest gaps and stalls on each side).
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES    = 9;
  localparam int ITEMS_PER_PHASE  = 203;

  // One expected result transaction.
  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic [G_W-1:0]  g;
    logic [F_W-1:0]  f;
    status_t         st;
  } reading_t;

  typedef logic [ADC_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fsr_sample_if sample_ch ();
  fsr_result_if result_ch ();

  fsr_adc_to_force_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, as written (zero divisors kept as zero).
  logic [MV_W-1:0]  supply_q;
  logic [OHM_W-1:0] divider_q;
  logic [MV_W-1:0]  full_scale_q;
  logic [G_W-1:0]   knee_q;
  logic [DIV_W-1:0] low_div_q;
  logic [DIV_W-1:0] high_div_q;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];

  int unsigned send_gap_max;
  int unsigned recv_stall_max;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned recv_draw;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  reading_t    want;

  // Compute the voltage, conductance, force and status of one ADC sample under the
  // current shadow configuration. All arithmetic is done in 64 bits and truncates.
  function automatic reading_t predict_reading(input sample_t adc);
    longint unsigned code, sup, ohms, fs, knee, lo, hi;
    longint unsigned mv, res, cond, frc;
    reading_t rd;
    code = adc;
    sup  = supply_q;
    ohms = divider_q;
    fs   = (full_scale_q == '0) ? 1 : full_scale_q;
    knee = knee_q;
    lo   = (low_div_q == '0) ? 1 : low_div_q;
    hi   = (high_div_q == '0) ? 1 : high_div_q;
    // Clamp to the supply once the code reaches full scale.
    if (code >= fs)
      mv = sup;
    else
      mv = code * sup / fs;
    rd.st = ST_OK;
    if (mv == 0) begin
      cond  = 0;
      frc   = 0;
      rd.st = ST_NOPRESS;
    end else begin
      res = (sup - mv) * ohms / mv;
      if (res == 0) begin
        // Truncated resistance of zero: conductance and force pinned at full scale.
        cond  = G_MAX;
        frc   = FORCE_MAX;
        rd.st = ST_SAT;
      end else begin
        cond = G_SCALE / res;
        if (cond <= knee)
          frc = cond / lo;
        else
          frc = (cond - knee) / hi;
        if (frc > FORCE_MAX)
          frc = FORCE_MAX;
      end
    end
    rd.mv = mv[MV_W-1:0];
    rd.g  = cond[G_W-1:0];
    rd.f  = frc[F_W-1:0];
    return rd;
  endfunction

  // Draw a value spread over all orders of magnitude, from 1 up to limit.
  function automatic int unsigned log_random(input int unsigned limit);
    int unsigned bits;
    int unsigned val;
    bits = $urandom_range(0, 19);
    val  = (1 << bits) | ($urandom & ((1 << bits) - 1));
    return (val > limit) ? limit : val;
  endfunction

  // Mostly uniform codes, with extra weight at both ends of the ADC range.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 5))
      0:       return sample_t'($urandom_range(0, 15));
      1:       return sample_t'($urandom_range(1008, 1023));
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // Write all six registers on consecutive edges, then drop the write enable.
  // The shadow copy follows each write.
  task automatic set_config(input logic [MV_W-1:0] sup, input logic [OHM_W-1:0] ohms,
                            input logic [MV_W-1:0] fs, input logic [G_W-1:0] knee,
                            input logic [DIV_W-1:0] lo, input logic [DIV_W-1:0] hi);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SUPPLY;
    cfg_data  <= CFG_DATA_W'(sup);
    supply_q = sup;
    @(posedge clk);
    cfg_index <= CFG_DIVIDER;
    cfg_data  <= CFG_DATA_W'(ohms);
    divider_q = ohms;
    @(posedge clk);
    cfg_index <= CFG_FULL_SCALE;
    cfg_data  <= CFG_DATA_W'(fs);
    full_scale_q = fs;
    @(posedge clk);
    cfg_index <= CFG_KNEE;
    cfg_data  <= CFG_DATA_W'(knee);
    knee_q = knee;
    @(posedge clk);
    cfg_index <= CFG_LOW_DIV;
    cfg_data  <= CFG_DATA_W'(lo);
    low_div_q = lo;
    @(posedge clk);
    cfg_index <= CFG_HIGH_DIV;
    cfg_data  <= CFG_DATA_W'(hi);
    high_div_q = hi;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hand a batch of samples to the driver away from the active edge.
  task automatic send_batch(input sample_t batch[$]);
    @(negedge clk);
    foreach (batch[i])
      pending_samples.push_back(batch[i]);
  endtask

  // Hold until the driver is empty and every expected result has come back.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_readings.size() != 0);
  endtask

  // Pick the idle pattern of one phase: none, light or heavy on each side.
  task automatic choose_pace();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    send_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
    pick = $urandom_range(0, 2);
    recv_stall_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
  endtask

  // Driver: present one sample per transaction, idle a drawn number of cycles after
  // each one, and predict the result of every sample at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        expected_readings.push_back(predict_reading(sample_ch.adc_sample));
      // Advance only once the current transaction (if any) has gone through.
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_wait != 0) begin
          sample_ch.valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_samples.size() != 0) begin
          sample_ch.valid      <= 1'b1;
          sample_ch.adc_sample <= pending_samples.pop_front();
          send_wait <= $urandom_range(0, send_gap_max);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then stall
  // ready for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("result transaction with no expected reading: mv=%0d g=%0d f=%0d st=%0d",
               result_ch.sense_millivolts, result_ch.conductance_micromho,
               result_ch.force_estimate, result_ch.status_code);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        if (result_ch.sense_millivolts !== want.mv) begin
          $error("sense_millivolts: expected %0d, actual %0d",
                 want.mv, result_ch.sense_millivolts);
          mismatch_count++;
        end
        if (result_ch.conductance_micromho !== want.g) begin
          $error("conductance_micromho: expected %0d, actual %0d",
                 want.g, result_ch.conductance_micromho);
          mismatch_count++;
        end
        if (result_ch.force_estimate !== want.f) begin
          $error("force_estimate: expected %0d, actual %0d",
                 want.f, result_ch.force_estimate);
          mismatch_count++;
        end
        if (result_ch.status_code !== want.st) begin
          $error("status_code: expected %0d, actual %0d",
                 want.st, result_ch.status_code);
          mismatch_count++;
        end
      end
      recv_draw = $urandom_range(0, recv_stall_max);
      result_ch.ready <= (recv_draw == 0);
      recv_wait <= recv_draw;
    end else if (recv_wait != 0) begin
      result_ch.ready <= (recv_wait == 1);
      recv_wait <= recv_wait - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog: drop the run if the pipeline stops delivering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value from time zero and hold reset.
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_SUPPLY;
    cfg_data  = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    result_ch.ready      = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    send_gap_max   = 2;
    recv_stall_max = 8;
    // The shadow registers start at the reset defaults.
    supply_q     = RST_SUPPLY;
    divider_q    = RST_DIVIDER;
    full_scale_q = RST_FULL_SCALE;
    knee_q       = RST_KNEE;
    low_div_q    = RST_LOW_DIV;
    high_div_q   = RST_HIGH_DIV;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: zero voltage, smallest nonzero voltage, both sides of the
    // knee, and codes just below and at full scale; only the full-scale code saturates.
    send_batch('{10'd0, 10'd1, 10'd2, 10'd300, 10'd700, 10'd1000, 10'd1022, 10'd1023});
    wait_drained();

    // Upper extremes of supply and full scale, smallest nonzero divider, knee at zero
    // and unit slopes: everything runs on the high-slope branch.
    set_config(16'd65535, 20'd1, 16'd65535, 20'd0, 8'd1, 8'd1);
    send_batch('{10'd1, 10'd512, 10'd1023});
    wait_drained();

    // Small resistances push the force past its maximum; the top code saturates.
    set_config(16'd5000, 20'd100, 16'd1023, 20'd1000000, 8'd1, 8'd1);
    send_batch('{10'd900, 10'd1000, 10'd1022});
    wait_drained();

    // Opposite extremes: one millivolt supply, a million-ohm divider, full scale of one.
    set_config(16'd1, 20'd1000000, 16'd1, 20'd1000000, 8'd255, 8'd255);
    send_batch('{10'd0, 10'd1023});
    wait_drained();

    // Slope divisors written as zero act as one, on both sides of the knee.
    set_config(16'd5000, 20'd10000, 16'd1023, 20'd1000, 8'd0, 8'd0);
    send_batch('{10'd200, 10'd600, 10'd1000});
    wait_drained();

    // Full scale written as zero acts as one: any nonzero code clamps to the supply.
    set_config(16'd5000, 20'd10000, 16'd0, 20'd1000, 8'd80, 8'd30);
    send_batch('{10'd0, 10'd1, 10'd1023});
    wait_drained();

    // Random phases: fresh configuration, fresh idle pattern, a few hundred samples.
    // Each phase drains completely before its registers are rewritten.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      automatic sample_t batch[$];
      automatic logic [MV_W-1:0]  sup;
      automatic logic [MV_W-1:0]  fs;
      automatic logic [G_W-1:0]   knee;
      case ($urandom_range(0, 3))
        0:       sup = 16'd5000;
        1:       sup = 16'd3300;
        default: sup = MV_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: fs = 16'd1023;
        3, 4:    fs = MV_W'($urandom_range(1, 1023));
        5:       fs = MV_W'($urandom_range(1024, 65535));
        6:       fs = 16'd0;
        default: fs = MV_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       knee = 20'd0;
        1:       knee = G_W'($urandom_range(0, 1000000));
        default: knee = G_W'(log_random(1000000));
      endcase
      set_config(sup, OHM_W'(log_random(1000000)), fs, knee,
                 DIV_W'($urandom_range(0, 255)), DIV_W'($urandom_range(0, 255)));
      choose_pace();
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        batch.push_back(random_sample());
      send_batch(batch);
      wait_drained();
    end

    // Let the pipeline settle so any stray result would still be caught.
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
